>>> rtl/core/bedmp_pkg.sv
package bedmp_pkg;

  localparam int MEM_BYTES_DEF = 1024;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [2:0] LEN_BYTE = 3'd1;
  localparam logic [2:0] LEN_HALF = 3'd2;
  localparam logic [2:0] LEN_TRI  = 3'd3;
  localparam logic [2:0] LEN_WORD = 3'd4;

  localparam logic [31:0] HALF_HI_MASK = 32'hFFFF_0000;
  localparam logic [31:0] HALF_LO_MASK = 32'h0000_FFFF;
  localparam logic [31:0] BYTE_LO_MASK = 32'h0000_00FF;

  typedef struct packed {
    logic       range_err;
    logic       mis_err;
    logic       acc;       // access goes to memory
    logic       is_write;
    logic [2:0] length;
    logic [1:0] lane;
  } chk_t;

  // residue mod 3 of an unsigned word by folding (2^2k == 1 mod 3)
  function automatic logic [1:0] mod3_u32(input logic [31:0] a);
    logic [16:0] s1;
    logic [9:0]  s2;
    logic [6:0]  s3;
    logic [4:0]  s4;
    logic [3:0]  s5;
    logic [2:0]  s6;
    s1 = {1'b0, a[31:16]} + {1'b0, a[15:0]};
    s2 = {1'b0, s1[16:8]} + {2'b00, s1[7:0]};
    s3 = {1'b0, s2[9:4]} + {3'b000, s2[3:0]};
    s4 = {2'b00, s3[6:4]} + {1'b0, s3[3:0]};
    s5 = {1'b0, s4[4:2]} + {2'b00, s4[1:0]};
    s6 = {1'b0, s5[3:2]} + {1'b0, s5[1:0]};
    if (s6 >= 3'd3) s6 = s6 - 3'd3;
    return s6[1:0];
  endfunction

  // big-endian lane merge of a store into the old word
  function automatic logic [31:0] merge_word(input logic [31:0] word,
                                             input logic [31:0] wdata,
                                             input logic [2:0]  length,
                                             input logic [1:0]  lane);
    logic [4:0]  sh;
    logic [31:0] res;
    sh  = {~lane, 3'b000};
    res = word;
    case (length)
      LEN_WORD: res = wdata;
      LEN_HALF: begin
        if (lane == 2'd2) res = (word & HALF_HI_MASK) | (wdata & HALF_LO_MASK);
        else              res = (word & HALF_LO_MASK) | ((wdata & HALF_LO_MASK) << 16);
      end
      LEN_BYTE: res = (word & ~(BYTE_LO_MASK << sh)) | ((wdata & BYTE_LO_MASK) << sh);
      default:  res = word;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] extract_word(input logic [31:0] word,
                                               input logic [2:0]  length,
                                               input logic [1:0]  lane);
    logic [4:0]  sh;
    logic [31:0] res;
    sh  = {~lane, 3'b000};
    res = '0;
    case (length)
      LEN_WORD: res = word;
      LEN_HALF: begin
        if (lane == 2'd2) res = word & HALF_LO_MASK;
        else              res = word >> 16;
      end
      LEN_BYTE: res = (word >> sh) & BYTE_LO_MASK;
      default:  res = '0;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/core/bedmp_if.sv
interface bedmp_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] address;
  logic        [2:0]  length;
  logic        [31:0] write_data;

  modport source (output valid, kind, address, length, write_data, input ready);
  modport sink   (input valid, kind, address, length, write_data, output ready);
endinterface

interface bedmp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        range_error;
  logic        misalign_error;
  logic        halted;

  modport source (output valid, read_data, range_error, misalign_error, halted,
                  input ready);
  modport sink   (input valid, read_data, range_error, misalign_error, halted,
                  output ready);
endinterface

>>> rtl/core/bedmp_check.sv
module bedmp_check import bedmp_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        kind,
  input  logic [31:0] address,
  input  logic [2:0]  length,
  output chk_t        chk
);

  localparam logic [32:0] LAST_BYTE = 33'(MEM_BYTES - 1);

  logic        len_ok;
  logic        neg;
  logic [32:0] last;
  logic        mis;
  logic [1:0]  r3;

  assign len_ok = (length >= LEN_BYTE) && (length <= LEN_WORD);
  assign neg    = address[31];
  assign last   = {1'b0, address} + {30'd0, length} - 33'd1;
  assign r3     = mod3_u32(address);

  // signed value divisible by 3 iff raw residue equals the sign (2^32 == 1 mod 3)
  always_comb begin
    unique case (length)
      LEN_BYTE: mis = 1'b0;
      LEN_HALF: mis = address[0];
      LEN_TRI:  mis = (r3 != {1'b0, neg});
      LEN_WORD: mis = |address[1:0];
      default:  mis = 1'b0;
    endcase
  end

  always_comb begin
    chk.range_err = len_ok && (neg || (last > LAST_BYTE));
    chk.mis_err   = len_ok && mis;
    chk.acc       = len_ok && !chk.range_err && !chk.mis_err && (length != LEN_TRI);
    chk.is_write  = (kind == KIND_WRITE);
    chk.length    = length;
    chk.lane      = address[1:0];
  end

endmodule

>>> rtl/core/bedmp_mem.sv
module bedmp_mem #(
  parameter int WORDS = 256,
  parameter int IW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_idx,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  logic [31:0]   wr_data,
  output logic          mem_ready
);

  logic [31:0]   mem [WORDS];
  logic [31:0]   rd_data_r;
  logic          clr_busy_r, clr_busy_nxt;
  logic [IW-1:0] clr_idx_r, clr_idx_nxt;
  logic          we;
  logic [IW-1:0] widx;
  logic [31:0]   wdat;

  // zeroing sweep after reset, one word a cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      if (clr_idx_r == IW'(WORDS - 1)) clr_busy_nxt = 1'b0;
      else                             clr_idx_nxt  = clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  assign we   = clr_busy_r || wr_en;
  assign widx = clr_busy_r ? clr_idx_r : wr_idx;
  assign wdat = clr_busy_r ? 32'd0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) mem[widx] <= wdat;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_idx];
  end

  assign rd_data   = rd_data_r;
  assign mem_ready = !clr_busy_r;

endmodule

>>> rtl/core/big_endian_data_memory_port_unit.sv
// Big-endian data memory port, 32-bit words.
// in_ch (sink): one access per item: kind (0 read, 1 write), signed byte
//   address, length (1 byte, 2 halfword, 4 word; 3 checked no-op) and
//   write_data. out_ch (source): one result per item: zero-extended
//   read_data, range_error, misalign_error and the sticky halted flag.
// An item is read from the word memory in the cycle it is accepted and
// held in stage s1; once the output register is free or being taken, s1
// merges the lane, writes the word back, and the result enters the output
// register. Stage s1 holds one item at a time, so the unit takes no new
// item until s1 has passed it on, set by the read-then-write of the single
// memory port pair. The output register lets a new item in while a result
// waits. Reset: halted clears and a sweep writes zero to every word,
// (MEM_BYTES+3)/4 words (256 at the default size); in_ch.ready stays low
// until it ends. A stalled out_ch holds its result; once the stage behind it
// holds an item, that stage holds too and no new item is taken.
module big_endian_data_memory_port_unit import bedmp_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bedmp_in_if.sink    in_ch,
  bedmp_out_if.source out_ch
);

  localparam int WORDS = (MEM_BYTES + 3) / 4;
  localparam int IW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  chk_t          chk;
  logic          mem_ready;
  logic          accept;
  logic          adv;
  logic [31:0]   rd_word;
  logic          wr_en;
  logic [31:0]   new_word;

  logic          s1_valid_r, s1_valid_nxt;
  chk_t          s1_chk_r;
  logic [31:0]   s1_wdata_r;
  logic [IW-1:0] s1_idx_r;

  logic          halt_r, halt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r;
  logic          out_rerr_r;
  logic          out_merr_r;
  logic          out_halt_r;

  bedmp_check #(.MEM_BYTES(MEM_BYTES)) u_check (
    .kind    (in_ch.kind),
    .address (in_ch.address),
    .length  (in_ch.length),
    .chk     (chk)
  );

  bedmp_mem #(.WORDS(WORDS), .IW(IW)) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_idx    (in_ch.address[IW+1:2]),
    .rd_data   (rd_word),
    .wr_en     (wr_en),
    .wr_idx    (s1_idx_r),
    .wr_data   (new_word),
    .mem_ready (mem_ready)
  );

  assign in_ch.ready = mem_ready && !s1_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);

  assign new_word = merge_word(rd_word, s1_wdata_r, s1_chk_r.length, s1_chk_r.lane);
  assign wr_en    = adv && s1_chk_r.acc && s1_chk_r.is_write;
  assign halt_nxt = halt_r || (adv && (s1_chk_r.range_err || s1_chk_r.mis_err));

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept)   s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (adv)               out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      halt_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      halt_r      <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_chk_r   <= chk;
      s1_wdata_r <= in_ch.write_data;
      s1_idx_r   <= in_ch.address[IW+1:2];
    end
    if (adv) begin
      out_data_r <= (s1_chk_r.acc && !s1_chk_r.is_write)
                    ? extract_word(rd_word, s1_chk_r.length, s1_chk_r.lane) : 32'd0;
      out_rerr_r <= s1_chk_r.range_err;
      out_merr_r <= s1_chk_r.mis_err;
      out_halt_r <= halt_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_data      = out_data_r;
  assign out_ch.range_error    = out_rerr_r;
  assign out_ch.misalign_error = out_merr_r;
  assign out_ch.halted         = out_halt_r;

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> mem_ready)
    else $error("item accepted during memory clear");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_chk_r))
    else $error("stalled stage lost its item");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.range_error || out_ch.misalign_error)
      |-> out_ch.halted && (out_ch.read_data == 32'd0))
    else $error("error result without halt or with data");

  a_no_write_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !s1_chk_r.range_err && !s1_chk_r.mis_err && mem_ready)
    else $error("memory written by a blocked access");
`endif

endmodule

>>> tb/big_endian_data_memory_port_unit_tb.sv
`timescale 1ns / 100ps

module big_endian_data_memory_port_unit_tb import bedmp_pkg::*; ();

  localparam int MEM_BYTES = MEM_BYTES_DEF;
  localparam int WORDS = (MEM_BYTES + 3) / 4;
  localparam int RANDOM_ITEMS = 1950;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [2:0]  len;
    logic [31:0] wdata;
  } access_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        rerr;
    logic        merr;
    logic        halt;
  } mem_result_t;

  typedef struct packed {
    access_t     acc;
    logic        typed;
    mem_result_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  bedmp_in_if  in_ch ();
  bedmp_out_if out_ch ();

  big_endian_data_memory_port_unit #(.MEM_BYTES(MEM_BYTES)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow memory and halt flag
  logic [31:0] mem_model [0:WORDS-1];
  logic        halt_model;

  mem_result_t pending_results [$];
  dir_row_t    dir_tab [$];
  int          err_count;
  int          results_seen;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic mem_result_t predict_access(input access_t a);
    mem_result_t r;
    longint      sa;
    longint      ln;
    int          idx;
    logic [1:0]  lane;
    logic [31:0] w;
    int          sh;
    r  = '0;
    sa = longint'($signed(a.addr));
    ln = longint'(a.len);
    if (a.len >= LEN_BYTE && a.len <= LEN_WORD) begin
      r.rerr = (sa < 0) || (sa + ln - 1 > MEM_BYTES - 1);
      r.merr = (sa % ln) != 0;
      if (r.rerr || r.merr) begin
        halt_model = 1'b1;
      end else begin
        idx  = int'(sa >> 2);
        lane = sa[1:0];
        w    = mem_model[idx];
        sh   = (3 - int'(lane)) * 8;
        case (a.len)
          LEN_WORD: begin
            if (a.kind == KIND_WRITE) mem_model[idx] = a.wdata;
            else r.rdata = w;
          end
          LEN_HALF: begin
            if (lane == 2'd2) begin
              if (a.kind == KIND_WRITE) mem_model[idx] = {w[31:16], a.wdata[15:0]};
              else r.rdata = {16'h0000, w[15:0]};
            end else begin
              if (a.kind == KIND_WRITE) mem_model[idx] = {a.wdata[15:0], w[15:0]};
              else r.rdata = {16'h0000, w[31:16]};
            end
          end
          LEN_BYTE: begin
            if (a.kind == KIND_WRITE) begin
              w[sh +: 8] = a.wdata[7:0];
              mem_model[idx] = w;
            end else begin
              r.rdata = {24'h000000, w[sh +: 8]};
            end
          end
          default: ;
        endcase
      end
    end
    r.halt = halt_model;
    return r;
  endfunction

  function automatic access_t rand_access();
    access_t a;
    int      r;
    int      sub;
    int      lim;
    a.kind  = 1'($urandom_range(0, 1));
    a.wdata = $urandom;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      // well-formed access, mostly in a small window so reads hit written data
      case ($urandom_range(0, 2))
        0: a.len = LEN_BYTE;
        1: a.len = LEN_HALF;
        default: a.len = LEN_WORD;
      endcase
      lim = ($urandom_range(0, 9) < 7) ? 63 : MEM_BYTES - 1;
      a.addr = 32'($urandom_range(0, lim)) & ~(32'(a.len) - 32'd1);
    end else if (r < 72) begin
      a.len  = LEN_TRI;
      a.addr = 32'($urandom_range(0, MEM_BYTES - 3));
      if ($urandom_range(0, 1) == 0) a.addr = (a.addr / 3) * 3;
    end else if (r < 84) begin
      a.len = 3'($urandom_range(1, 4));
      sub = $urandom_range(0, 3);
      case (sub)
        0: a.addr = -32'($urandom_range(1, 16));
        1: a.addr = 32'(MEM_BYTES - 8 + $urandom_range(0, 15));
        2: a.addr = 32'($urandom_range(0, MEM_BYTES - 8)) | 32'($urandom_range(1, 3));
        default: a.addr = $urandom | 32'h8000_0000;
      endcase
    end else if (r < 90) begin
      sub = $urandom_range(0, 3);
      a.len  = (sub == 0) ? 3'd0 : 3'(4 + sub);
      a.addr = $urandom;
    end else begin
      a.len  = 3'($urandom_range(0, 7));
      a.addr = $urandom;
    end
    return a;
  endfunction

  task automatic add_row(input logic k, input logic [31:0] ad, input logic [2:0] ln,
                         input logic [31:0] wd, input logic typed,
                         input logic [31:0] rd, input logic re, input logic me,
                         input logic h);
    dir_row_t row;
    row.acc.kind  = k;
    row.acc.addr  = ad;
    row.acc.len   = ln;
    row.acc.wdata = wd;
    row.typed     = typed;
    row.res.rdata = rd;
    row.res.rerr  = re;
    row.res.merr  = me;
    row.res.halt  = h;
    dir_tab.push_back(row);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 40)
      $display("%0t: result %0d %s: got %h want %h", $realtime, results_seen, what, got, want);
  endtask

  task automatic send_access(input access_t a, input logic typed, input mem_result_t fixed);
    mem_result_t pred;
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= a.kind;
    in_ch.address    <= a.addr;
    in_ch.length     <= a.len;
    in_ch.write_data <= a.wdata;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = predict_access(a);
    pending_results.push_back(typed ? fixed : pred);
  endtask

  task automatic idle_in(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    mem_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("no item pending", {31'd0, out_ch.valid}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.read_data !== want.rdata)
          report_mismatch("read_data", out_ch.read_data, want.rdata);
        if (out_ch.range_error !== want.rerr)
          report_mismatch("range_error", {31'd0, out_ch.range_error}, {31'd0, want.rerr});
        if (out_ch.misalign_error !== want.merr)
          report_mismatch("misalign_error", {31'd0, out_ch.misalign_error},
                          {31'd0, want.merr});
        if (out_ch.halted !== want.halt)
          report_mismatch("halted", {31'd0, out_ch.halted}, {31'd0, want.halt});
      end
      results_seen++;
    end
  end

  // result side: random stalls, plus one long hold-off to back up the input
  initial begin
    int  n;
    int  m;
    int  r;
    bit  held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      n = (r < 10) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      r = $urandom_range(0, 99);
      m = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      out_ch.ready <= 1'b1;
      repeat (n + 1) @(posedge clk);
      if (m > 0) begin
        out_ch.ready <= 1'b0;
        repeat (m) @(posedge clk);
      end
    end
  end

  initial begin
    access_t     a;
    mem_result_t none;
    int          quiet_left;
    none = '0;
    err_count = 0;
    results_seen = 0;
    quiet_left = 0;
    halt_model = 1'b0;
    for (int i = 0; i < WORDS; i++) mem_model[i] = '0;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_READ;
    in_ch.address    <= '0;
    in_ch.length     <= LEN_WORD;
    in_ch.write_data <= '0;

    //       kind        address        len       wdata          typed rdata re me h
    add_row(KIND_READ,  32'd0,         LEN_WORD, 32'h0,         1, 32'h0, 0, 0, 0);
    add_row(KIND_WRITE, 32'd0,         LEN_WORD, 32'hDEADBEEF,  1, 32'h0, 0, 0, 0);
    add_row(KIND_READ,  32'd0,         LEN_BYTE, 32'h0,         0, 32'h0, 0, 0, 0);
    add_row(KIND_READ,  32'd1,         LEN_BYTE, 32'h0,         0, 32'h0, 0, 0, 0);
    add_row(KIND_READ,  32'd3,         LEN_BYTE, 32'h0,         0, 32'h0, 0, 0, 0);
    add_row(KIND_READ,  32'd0,         LEN_HALF, 32'h0,         0, 32'h0, 0, 0, 0);
    add_row(KIND_READ,  32'd2,         LEN_HALF, 32'h0,         0, 32'h0, 0, 0, 0);
    add_row(KIND_WRITE, 32'd1,         LEN_BYTE, 32'h12345655,  0, 32'h0, 0, 0, 0);
    add_row(KIND_WRITE, 32'd2,         LEN_HALF, 32'hFFFFA5A5,  0, 32'h0, 0, 0, 0);
    add_row(KIND_READ,  32'd0,         LEN_WORD, 32'h0,         0, 32'h0, 0, 0, 0);
    add_row(KIND_WRITE, 32'd1020,      LEN_WORD, 32'hFFFFFFFF,  1, 32'h0, 0, 0, 0);
    add_row(KIND_WRITE, 32'd1023,      LEN_BYTE, 32'h0,         0, 32'h0, 0, 0, 0);
    add_row(KIND_READ,  32'd1020,      LEN_WORD, 32'h0,         0, 32'h0, 0, 0, 0);
    // undefined lengths: no check at all, even on bad addresses
    add_row(KIND_WRITE, 32'h8000_0000, 3'd0,     32'hFFFFFFFF,  1, 32'h0, 0, 0, 0);
    add_row(KIND_READ,  32'hFFFF_FFFF, 3'd5,     32'h0,         1, 32'h0, 0, 0, 0);
    add_row(KIND_WRITE, 32'd1025,      3'd7,     32'h0,         1, 32'h0, 0, 0, 0);
    // length three: checked, otherwise no effect
    add_row(KIND_READ,  32'd1020,      LEN_TRI,  32'h0,         1, 32'h0, 0, 0, 0);
    add_row(KIND_WRITE, 32'd0,         LEN_TRI,  32'hFFFFFFFF,  1, 32'h0, 0, 0, 0);
    add_row(KIND_READ,  32'd0,         LEN_WORD, 32'h0,         0, 32'h0, 0, 0, 0);
    // errors set the sticky halt
    add_row(KIND_READ,  32'hFFFF_FFFF, LEN_BYTE, 32'h0,         1, 32'h0, 1, 0, 1);
    add_row(KIND_READ,  32'd1022,      LEN_WORD, 32'h0,         1, 32'h0, 1, 1, 1);
    add_row(KIND_WRITE, 32'h8000_0000, LEN_WORD, 32'h55555555,  1, 32'h0, 1, 0, 1);
    add_row(KIND_READ,  32'h7FFF_FFFF, LEN_BYTE, 32'h0,         1, 32'h0, 1, 0, 1);
    add_row(KIND_READ,  32'd1021,      LEN_TRI,  32'h0,         1, 32'h0, 0, 1, 1);
    add_row(KIND_READ,  32'd1023,      LEN_TRI,  32'h0,         1, 32'h0, 1, 0, 1);
    add_row(KIND_WRITE, 32'd1,         LEN_HALF, 32'h0,         1, 32'h0, 0, 1, 1);
    // accesses still work once halted
    add_row(KIND_WRITE, 32'd8,         LEN_WORD, 32'h01020304,  1, 32'h0, 0, 0, 1);
    add_row(KIND_READ,  32'd8,         LEN_WORD, 32'h0,         1, 32'h01020304, 0, 0, 1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_access(dir_tab[i].acc, dir_tab[i].typed, dir_tab[i].res);
      idle_in(pick_gap());
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      a = rand_access();
      send_access(a, 1'b0, none);
      if (quiet_left > 0) begin
        quiet_left--;
      end else if ($urandom_range(0, 99) < 3) begin
        quiet_left = $urandom_range(30, 80);
      end else begin
        idle_in(pick_gap());
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
